FILE: rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int KEY_WORDS = 4;
  localparam int CFG_AW    = 2;
  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] rc4_key_t;

  localparam rc4_key_t KEY_RESET = {
    32'h0163_5943, 32'h3843_2CE9, 32'h0403_050B, 32'h1604_B2DE
  };

  // one queued request; sched marks the first byte of a block
  typedef struct packed {
    logic              sched;
    logic              last;
    logic [BYTE_W-1:0] data;
  } rc4_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_J,
    ST_KS_WN,
    ST_KS_WJ,
    ST_GOT_I,
    ST_GOT_J,
    ST_WR_J,
    ST_GOT_T
  } eng_state_t;

  // key byte n (mod 16): word n[3:2], byte lane n[1:0]
  function automatic logic [BYTE_W-1:0] key_byte(input rc4_key_t key,
                                                 input logic [3:0] n);
    logic [WORD_W-1:0] w;
    w = key[n[3:2]];
    key_byte = w[{n[1:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

FILE: rtl/rc4_front.sv
module rc4_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rc4_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                           in_tlast,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [rc4_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                           q_full,
  output logic                           q_push,
  output rc4_pkg::rc4_item_t             q_item,
  output rc4_pkg::rc4_key_t              key
);
  import rc4_pkg::*;

  rc4_key_t key_r, key_nxt;
  logic     sched_pend_r, sched_pend_nxt;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign key       = key_r;

  always_comb begin
    q_item.data  = in_tdata;
    q_item.last  = in_tlast;
    q_item.sched = sched_pend_r;
    sched_pend_nxt = sched_pend_r;
    if (q_push) begin
      sched_pend_nxt = in_tlast;
    end
    key_nxt = key_r;
    if (cfg_we) begin
      key_nxt[cfg_addr] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= KEY_RESET;
      sched_pend_r <= 1'b1;
    end else begin
      key_r        <= key_nxt;
      sched_pend_r <= sched_pend_nxt;
    end
  end

endmodule

FILE: rtl/rc4_queue.sv
module rc4_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rc4_pkg::rc4_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output rc4_pkg::rc4_item_t q_item
);
  import rc4_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rc4_item_t         slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/rc4_engine.sv
module rc4_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  rc4_pkg::rc4_item_t         q_item,
  output logic                       pop,
  input  rc4_pkg::rc4_key_t          key,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rc4_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import rc4_pkg::*;

  localparam logic [BYTE_W-1:0] LAST_IDX = '1;

  // S-box: one write and one registered read per cycle
  logic [BYTE_W-1:0] sbox [256];
  logic              we, re;
  logic [BYTE_W-1:0] waddr, wdata, raddr, rdata_r;

  eng_state_t        state_r, state_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [BYTE_W-1:0] si_r, si_nxt, sj_r, sj_nxt;
  logic [BYTE_W-1:0] cur_data_r, cur_data_nxt;
  logic              cur_last_r, cur_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free, launch;
  logic [BYTE_W-1:0] j_sum;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    cur_data_nxt  = cur_data_r;
    cur_last_nxt  = cur_last_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    re     = 1'b0;
    raddr  = '0;
    pop    = 1'b0;
    launch = 1'b0;
    j_sum  = '0;

    case (state_r)
      ST_IDLE: begin
        launch = 1'b1;
      end
      ST_INIT: begin
        we      = 1'b1;
        waddr   = cnt_r;
        wdata   = cnt_r;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == LAST_IDX) begin
          re        = 1'b1;
          raddr     = '0;
          j_nxt     = '0;
          state_nxt = ST_KS_J;
        end
      end
      ST_KS_J: begin
        j_sum     = j_r + rdata_r + key_byte(key, cnt_r[3:0]);
        si_nxt    = rdata_r;
        j_nxt     = j_sum;
        re        = 1'b1;
        raddr     = j_sum;
        state_nxt = ST_KS_WN;
      end
      ST_KS_WN: begin
        we        = 1'b1;
        waddr     = cnt_r;
        wdata     = rdata_r;
        state_nxt = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = si_r;
        re    = 1'b1;
        if (cnt_r == LAST_IDX) begin
          // schedule done: first keystream step reads S[1]
          i_nxt     = 8'd1;
          j_nxt     = '0;
          raddr     = 8'd1;
          state_nxt = ST_GOT_I;
        end else begin
          cnt_nxt   = cnt_r + 8'd1;
          raddr     = cnt_r + 8'd1;
          state_nxt = ST_KS_J;
        end
      end
      ST_GOT_I: begin
        j_sum     = j_r + rdata_r;
        si_nxt    = rdata_r;
        j_nxt     = j_sum;
        re        = 1'b1;
        raddr     = j_sum;
        state_nxt = ST_GOT_J;
      end
      ST_GOT_J: begin
        we        = 1'b1;
        waddr     = i_r;
        wdata     = rdata_r;
        sj_nxt    = rdata_r;
        state_nxt = ST_WR_J;
      end
      ST_WR_J: begin
        we        = 1'b1;
        waddr     = j_r;
        wdata     = si_r;
        re        = 1'b1;
        raddr     = si_r + sj_r;
        state_nxt = ST_GOT_T;
      end
      ST_GOT_T: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cur_data_r ^ rdata_r;
          out_last_nxt  = cur_last_r;
          launch        = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // pick up the next request, running the key schedule first if marked
    if (launch) begin
      if (q_valid) begin
        pop          = 1'b1;
        cur_data_nxt = q_item.data;
        cur_last_nxt = q_item.last;
        if (q_item.sched) begin
          cnt_nxt   = '0;
          state_nxt = ST_INIT;
        end else begin
          i_nxt     = i_r + 8'd1;
          re        = 1'b1;
          raddr     = i_r + 8'd1;
          state_nxt = ST_GOT_I;
        end
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    cur_data_r <= cur_data_nxt;
    cur_last_r <= cur_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // write-through on same-address read keeps back-to-back swaps coherent
  always_ff @(posedge clk) begin
    if (we) begin
      sbox[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : sbox[raddr];
    end
  end

endmodule

FILE: rtl/rc4_block_cipher_stream_core.sv
// RC4 byte stream cipher.
// in_*  : request stream of bytes; in_tlast marks the last byte of a block.
// out_* : one result byte per request, in order, with tlast copied through.
// cfg_* : key write port, four 32-bit words (index 0..3), byte 0 in bits 7:0.
//         Writes take effect at the next key schedule.
// The first byte after reset or after a tlast byte runs the key schedule:
// it loads the identity permutation, then runs the swap steps (read S[j],
// write S[n], write S[j]), both on the single-write/single-read S-box memory.
// Each byte then reads S[i], reads S[j] and makes two swap writes, with the
// S[t] read folded into the second; the engine works on one byte at a time.
// A small request queue sits in front of the engine, so input is accepted
// while the engine works; when the receiver stalls, the output register
// holds its byte, the engine waits and the queue fills, then in_tready drops.
// Reset restores the default key and marks a key schedule pending.
module rc4_block_cipher_stream_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rc4_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // block_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rc4_pkg::BYTE_W-1:0]     out_tdata,  // [7:0] cipher_byte
  output logic                           out_tlast,  // block_end_out
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [rc4_pkg::WORD_W-1:0]     cfg_wdata
);
  import rc4_pkg::*;

  logic      q_full, q_push, q_pop, q_valid;
  rc4_item_t push_item, head_item;
  rc4_key_t  key;

  rc4_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item),
    .key       (key)
  );

  rc4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (head_item)
  );

  rc4_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .pop        (q_pop),
    .key        (key),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: test/tb.sv
module tb;
  import rc4_pkg::*;

  localparam logic [CFG_AW-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_AW-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_AW-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_AW-1:0] REG_KEY3 = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 200;

  typedef enum logic {ROW_BYTE, ROW_KEY} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CFG_AW-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher;
    logic              last;
  } cipher_exp_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [BYTE_W-1:0]   out_tdata;
  logic                out_tlast;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [WORD_W-1:0]   cfg_wdata;

  // cipher state mirrored by the predictor
  logic [BYTE_W-1:0]   sbox [256];
  logic [BYTE_W-1:0]   ks_i;
  logic [BYTE_W-1:0]   ks_j;
  logic                rekey_pending;
  logic [WORD_W-1:0]   key_word [KEY_WORDS];

  cipher_exp_t         cipher_q [$];
  int                  err_count;
  logic                calm;

  // directed part: extremes, single-byte blocks, key change mid-block
  stim_row_t directed_rows [21] = '{
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'hFF, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'hAA, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h55, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h01, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h80, 1'b1},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h00, 1'b1},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'hFF, 1'b1},
    '{ROW_KEY,  REG_KEY0, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY1, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY2, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY3, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h00, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'hFF, 1'b0},
    '{ROW_KEY,  REG_KEY0, 32'hFFFF_FFFF, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY1, 32'hFFFF_FFFF, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY2, 32'hFFFF_FFFF, 8'h00, 1'b0},
    '{ROW_KEY,  REG_KEY3, 32'hFFFF_FFFF, 8'h00, 1'b0},
    // block still open: zero key stays in use until the mark below
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h3C, 1'b1},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'hC3, 1'b0},
    '{ROW_BYTE, REG_KEY0, 32'h0000_0000, 8'h00, 1'b1}
  };

  rc4_block_cipher_stream_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tlast   (in_tlast),    // block_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] cipher_byte
    .out_tlast  (out_tlast),   // block_end_out
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // key schedule: identity, then 256 swaps with the 16-byte key repeated
  function automatic void rc4_schedule();
    int n;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] tmp;
    for (n = 0; n < 256; n++) begin
      sbox[n] = n[BYTE_W-1:0];
    end
    j = '0;
    for (n = 0; n < 256; n++) begin
      kb = key_word[(n >> 2) & 3][8 * (n & 3) +: 8];
      j = j + sbox[n] + kb;
      tmp = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = tmp;
    end
    ks_i = '0;
    ks_j = '0;
    rekey_pending = 1'b0;
  endfunction

  function automatic logic [BYTE_W-1:0] rc4_keystream();
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] t;
    if (rekey_pending) begin
      rc4_schedule();
    end
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    tmp = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = tmp;
    t = sbox[ks_i] + sbox[ks_j];
    return sbox[t];
  endfunction

  always @(posedge clk) begin : monitor
    cipher_exp_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result: cipher_byte=%02h block_end_out=%0b",
                 out_tdata, out_tlast);
          err_count++;
        end else begin
          e = cipher_q.pop_front();
          if (out_tdata !== e.cipher) begin
            $error("cipher_byte: expected %02h, got %02h", e.cipher, out_tdata);
            err_count++;
          end
          if (out_tlast !== e.last) begin
            $error("block_end_out: expected %0b, got %0b", e.last, out_tlast);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        e.cipher = in_tdata ^ rc4_keystream();
        e.last = in_tlast;
        if (in_tlast) begin
          rekey_pending = 1'b1;
        end
        cipher_q.push_back(e);
      end
      if (cfg_we) begin
        key_word[cfg_addr] = cfg_wdata;
      end
    end
  end

  always @(negedge clk) begin
    out_tready = calm || ($urandom_range(99) >= 12);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic l);
    while (!calm && $urandom_range(99) < 12) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = d;
    in_tlast = l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_key(input logic [CFG_AW-1:0] a, input logic [WORD_W-1:0] v);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int r;
    int ph;
    int w;
    int left;
    int blen;
    int k;
    logic [WORD_W-1:0] v;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    err_count = 0;
    key_word[0] = 32'h1604_B2DE;
    key_word[1] = 32'h0403_050B;
    key_word[2] = 32'h3843_2CE9;
    key_word[3] = 32'h0163_5943;
    ks_i = '0;
    ks_j = '0;
    rekey_pending = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < $size(directed_rows); r++) begin
      if (directed_rows[r].kind == ROW_KEY) begin
        wait_drained();
        write_key(directed_rows[r].addr, directed_rows[r].word);
      end else begin
        send_byte(directed_rows[r].data, directed_rows[r].last);
      end
    end

    // random phases; a phase may stop mid-block, so new keys wait for the mark
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      calm = (ph == 3);
      for (w = 0; w < KEY_WORDS; w++) begin
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            default: v = $urandom;
          endcase
          write_key(w[CFG_AW-1:0], v);
        end
      end
      left = PHASE_BYTES;
      while (left > 0) begin
        case ($urandom_range(9))
          0: blen = 1;
          1: blen = $urandom_range(100, 250);
          default: blen = $urandom_range(2, 40);
        endcase
        for (k = 0; k < blen && left > 0; k++) begin
          send_byte(8'($urandom_range(255)), k == blen - 1);
          left--;
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (16) @(negedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
